// ===== sv/uart_line_receiver_unit_macros.svh =====
// Assertion helpers for the line receiver
`ifndef UART_LINE_RECEIVER_UNIT_MACROS_SVH
`define UART_LINE_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ULR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ULR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ulr_pkg.sv =====
package ulr_pkg;

  // line buffer depth and position width
  localparam int LINE_DEPTH = 32;
  localparam int POS_W      = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int IDLE_W   = 8;

  // bit phases: start bit, data bits, stop bit, ready
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_DATA0 = 4'd1;
  localparam logic [3:0] PH_STOP  = 4'd9;
  localparam logic [3:0] PH_READY = 4'd10;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

  // idle timeout after reset
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 8'd240;

  // event kind
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_t;

  // line status of a result
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 2'd0,
    ST_TERM     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

endpackage

// ===== sv/uart_line_receiver_unit.sv =====
// 8N1 serial line receiver. Each input transaction is one event: a bit-time
// sample tick (tuser 0) or a line level change (tuser 1). A qualifying falling
// edge starts a frame; the next tick passes over the start bit, eight ticks shift
// in data LSB first and the stop-bit tick delivers the character (newline sent
// as zero) with its position in the line. A zero character ends the line, the
// last buffer slot aborts it, and idle ticks beyond idle_timeout_ticks end it
// by timeout. One event is taken per clock; each event passes through the input
// register, then the result register. Throughput drops below one per clock
// only while a result waits in the output register for tready.
`include "uart_line_receiver_unit_macros.svh"

module uart_line_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration: idle_timeout_ticks
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // input events
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] line_level, [1] tx_busy, [7:2] zero
  input  logic       s_axis_tuser,   // [0] cmd
  // results
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] rx_char, [12:8] char_index,
                                     // [14:13] line_status, [15] zero
  output logic       m_axis_tuser    // [0] char_valid
);

  localparam int POS_W = ulr_pkg::POS_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(ulr_pkg::LINE_DEPTH - 1);

  // configuration register
  logic [ulr_pkg::IDLE_W-1:0] idle_timeout;

  // input register
  logic                in_valid;
  ulr_pkg::cmd_t       in_cmd;
  logic                in_level;
  logic                in_busy;

  // receiver state
  logic                receiving,    receiving_next;
  logic [3:0]          bit_phase,    bit_phase_next;
  logic [ulr_pkg::CHAR_W-1:0] shift_reg, shift_reg_next;
  logic [POS_W-1:0]    write_pos,    write_pos_next;
  logic [ulr_pkg::IDLE_W-1:0] idle_count, idle_count_next;

  // result register
  logic                res_valid;
  logic                res_char_valid;
  logic [ulr_pkg::CHAR_W-1:0]  res_char;
  logic [ulr_pkg::INDEX_W-1:0] res_index;
  ulr_pkg::status_t    res_status;

  // computed result
  logic                gen;
  logic                gen_char_valid;
  logic [ulr_pkg::CHAR_W-1:0]  gen_char;
  logic [ulr_pkg::INDEX_W-1:0] gen_index;
  ulr_pkg::status_t    gen_status;

  logic                proc;
  logic [ulr_pkg::CHAR_W-1:0]  stop_char;
  logic [ulr_pkg::IDLE_W-1:0]  idle_sum;
  logic [POS_W+ulr_pkg::INDEX_W-1:0] pos_ext;

  // handshake: process the held event whenever the result register can take it
  assign proc          = in_valid && (!res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;

  assign stop_char = (shift_reg == ulr_pkg::CHAR_NL) ? ulr_pkg::CHAR_NUL : shift_reg;
  assign idle_sum  = idle_count + 1'b1;
  assign pos_ext   = {{ulr_pkg::INDEX_W{1'b0}}, write_pos};

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= ulr_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      idle_timeout <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd   <= ulr_pkg::cmd_t'(s_axis_tuser);
      in_level <= s_axis_tdata[0];
      in_busy  <= s_axis_tdata[1];
    end
  end

  // event processing
  always_comb begin
    receiving_next  = receiving;
    bit_phase_next  = bit_phase;
    shift_reg_next  = shift_reg;
    write_pos_next  = write_pos;
    idle_count_next = idle_count;
    gen             = 1'b0;
    gen_char_valid  = 1'b0;
    gen_char        = ulr_pkg::CHAR_NUL;
    gen_index       = '0;
    gen_status      = ulr_pkg::ST_NONE;
    if (proc) begin
      if (in_cmd == ulr_pkg::CMD_EDGE) begin
        // frame start on a falling edge while ready and not transmitting
        if (!in_level && !in_busy && bit_phase >= ulr_pkg::PH_READY) begin
          receiving_next = 1'b1;
          bit_phase_next = ulr_pkg::PH_START;
        end
      end else if (receiving) begin
        if (bit_phase == ulr_pkg::PH_START) begin
          idle_count_next = '0;
          shift_reg_next  = '0;
          bit_phase_next  = ulr_pkg::PH_DATA0;
        end else if (bit_phase < ulr_pkg::PH_STOP) begin
          shift_reg_next = {in_level, shift_reg[ulr_pkg::CHAR_W-1:1]};
          bit_phase_next = bit_phase + 4'd1;
        end else if (bit_phase == ulr_pkg::PH_STOP) begin
          // deliver character; terminator wins over buffer limit
          gen            = 1'b1;
          gen_char_valid = 1'b1;
          gen_char       = stop_char;
          gen_index      = pos_ext[ulr_pkg::INDEX_W-1:0];
          shift_reg_next = stop_char;
          bit_phase_next = ulr_pkg::PH_READY;
          write_pos_next = write_pos + 1'b1;
          if (stop_char == ulr_pkg::CHAR_NUL) begin
            gen_status     = ulr_pkg::ST_TERM;
            write_pos_next = '0;
            receiving_next = 1'b0;
          end else if (write_pos == POS_LAST) begin
            gen_status     = ulr_pkg::ST_OVERFLOW;
            write_pos_next = '0;
            receiving_next = 1'b0;
          end
        end else begin
          // ready phase: idle tick count
          idle_count_next = idle_sum;
          if (idle_sum > idle_timeout) begin
            gen            = 1'b1;
            gen_status     = ulr_pkg::ST_TIMEOUT;
            write_pos_next = '0;
            receiving_next = 1'b0;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving  <= 1'b0;
      bit_phase  <= ulr_pkg::PH_READY;
      shift_reg  <= '0;
      write_pos  <= '0;
      idle_count <= '0;
    end else begin
      receiving  <= receiving_next;
      bit_phase  <= bit_phase_next;
      shift_reg  <= shift_reg_next;
      write_pos  <= write_pos_next;
      idle_count <= idle_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= gen;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      res_char_valid <= gen_char_valid;
      res_char       <= gen_char;
      res_index      <= gen_index;
      res_status     <= gen_status;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_char_valid;
  assign m_axis_tdata  = {1'b0, res_status, res_index, res_char};

  // checks
  `ULR_ASSERT_NOW(a_pos_range, 1'b1, write_pos <= POS_LAST, "write position past buffer end")
  `ULR_ASSERT_NOW(a_frame_receiving, bit_phase < ulr_pkg::PH_READY, receiving,
    "frame in progress while not receiving")
  `ULR_ASSERT_NOW(a_timeout_form, res_valid && !res_char_valid,
    res_status == ulr_pkg::ST_TIMEOUT && res_char == ulr_pkg::CHAR_NUL,
    "non-character result is not a clean timeout")
  `ULR_ASSERT_NEXT(a_result_loaded, proc && gen, res_valid, "generated result lost")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int EVENT_TARGET = 1650;
  localparam int ROUND_EVENTS = 250;
  localparam int SETTLE       = 6;
  localparam int MAX_REPORTS  = 10;

  // one delivered character or line-ending notice
  typedef struct packed {
    logic                        valid;
    logic [ulr_pkg::CHAR_W-1:0]  ch;
    logic [ulr_pkg::INDEX_W-1:0] idx;
    ulr_pkg::status_t            status;
  } line_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] line_level, [1] tx_busy, [7:2] zero
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] rx_char, [12:8] char_index,
                               // [14:13] line_status, [15] zero
  logic        m_axis_tuser;   // [0] char_valid

  // receiver shadow state
  logic                       rx_active;
  logic [3:0]                 rx_phase;
  logic [ulr_pkg::CHAR_W-1:0] rx_shift;
  int                         rx_pos;
  logic [ulr_pkg::IDLE_W-1:0] rx_idle;
  logic [ulr_pkg::IDLE_W-1:0] rx_idle_limit;

  line_result_t pending_line_results[$];
  line_result_t want;

  int  mismatch_count;
  int  events_accepted;
  int  cycle_count;
  int  hold_req;
  int  hold_left;
  bit  no_idle;

  uart_line_receiver_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // advance the shadow receiver by one event, queue any result it yields
  task automatic predict_line_event(input ulr_pkg::cmd_t kind, input logic lvl,
                                    input logic busy);
    line_result_t r;
    logic [ulr_pkg::CHAR_W-1:0] ch;
    if (kind == ulr_pkg::CMD_EDGE) begin
      // frame start needs ready phase, low line, quiet transmitter
      if (!lvl && !busy && rx_phase >= ulr_pkg::PH_READY) begin
        rx_active = 1'b1;
        rx_phase  = ulr_pkg::PH_START;
      end
    end else if (rx_active) begin
      if (rx_phase == ulr_pkg::PH_START) begin
        rx_idle  = '0;
        rx_shift = '0;
        rx_phase = ulr_pkg::PH_DATA0;
      end else if (rx_phase < ulr_pkg::PH_STOP) begin
        rx_shift = {lvl, rx_shift[ulr_pkg::CHAR_W-1:1]};
        rx_phase = rx_phase + 4'd1;
      end else if (rx_phase == ulr_pkg::PH_STOP) begin
        ch       = (rx_shift == ulr_pkg::CHAR_NL) ? ulr_pkg::CHAR_NUL : rx_shift;
        r.valid  = 1'b1;
        r.ch     = ch;
        r.idx    = rx_pos[ulr_pkg::INDEX_W-1:0];
        r.status = ulr_pkg::ST_NONE;
        rx_shift = ch;
        rx_pos   = rx_pos + 1;
        rx_phase = ulr_pkg::PH_READY;
        // terminator first; it clears the position so no overflow follows
        if (ch == ulr_pkg::CHAR_NUL) begin
          r.status  = ulr_pkg::ST_TERM;
          rx_pos    = 0;
          rx_active = 1'b0;
        end
        if (rx_pos + 1 > ulr_pkg::LINE_DEPTH) begin
          r.status  = ulr_pkg::ST_OVERFLOW;
          rx_pos    = 0;
          rx_active = 1'b0;
        end
        pending_line_results.push_back(r);
      end else begin
        // idle tick after a character, counter wraps at 8 bits
        rx_idle = rx_idle + 1'b1;
        if (rx_idle > rx_idle_limit) begin
          rx_pos    = 0;
          rx_active = 1'b0;
          r = '{valid: 1'b0, ch: ulr_pkg::CHAR_NUL, idx: '0, status: ulr_pkg::ST_TIMEOUT};
          pending_line_results.push_back(r);
        end
      end
    end
  endtask

  // offer one event; returns at the falling edge after the transaction
  task automatic send_event(input ulr_pkg::cmd_t kind, input logic lvl, input logic busy);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, busy, lvl};
    s_axis_tuser  = kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_line_event(kind, lvl, busy);
    events_accepted++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // full 8N1 frame; glitch adds an edge inside the frame that must be ignored
  task automatic send_frame(input logic [ulr_pkg::CHAR_W-1:0] ch, input bit glitch);
    int i;
    send_event(ulr_pkg::CMD_EDGE, 1'b0, 1'b0);
    send_event(ulr_pkg::CMD_TICK, 1'b0, 1'($urandom_range(1)));
    if (glitch) send_event(ulr_pkg::CMD_EDGE, 1'b0, 1'b0);
    for (i = 0; i < ulr_pkg::CHAR_W; i++)
      send_event(ulr_pkg::CMD_TICK, ch[i], 1'($urandom_range(1)));
    send_event(ulr_pkg::CMD_TICK, 1'b1, 1'($urandom_range(1)));
  endtask

  function automatic logic [ulr_pkg::CHAR_W-1:0] plain_char();
    logic [ulr_pkg::CHAR_W-1:0] ch;
    do ch = ulr_pkg::CHAR_W'($urandom_range(255));
    while (ch == ulr_pkg::CHAR_NUL || ch == ulr_pkg::CHAR_NL);
    return ch;
  endfunction

  // wait for every expected result, then let the pipeline settle
  task automatic wait_drain();
    while (pending_line_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [ulr_pkg::IDLE_W-1:0] value);
    wait_drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    rx_idle_limit = value;
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_line_results.size() == 0) begin
        note_mismatch("result with nothing pending", 16'h0, m_axis_tdata);
      end else begin
        want = pending_line_results.pop_front();
        if (m_axis_tuser !== want.valid)
          note_mismatch("char_valid", 16'(want.valid), 16'(m_axis_tuser));
        if (m_axis_tdata[7:0] !== want.ch)
          note_mismatch("rx_char", 16'(want.ch), 16'(m_axis_tdata[7:0]));
        if (m_axis_tdata[12:8] !== want.idx)
          note_mismatch("char_index", 16'(want.idx), 16'(m_axis_tdata[12:8]));
        if (m_axis_tdata[14:13] !== want.status)
          note_mismatch("line_status", 16'(want.status), 16'(m_axis_tdata[14:13]));
      end
    end
  end

  // result side ready: random stalls, plus a counted hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = no_idle || ($urandom_range(99) >= 33);
      end
    end
  end

  // ignored edges, idle ticks, a frame with a stray edge, newline as terminator
  task automatic test_directed();
    send_event(ulr_pkg::CMD_EDGE, 1'b1, 1'b0);
    send_event(ulr_pkg::CMD_EDGE, 1'b0, 1'b1);
    send_event(ulr_pkg::CMD_EDGE, 1'b1, 1'b1);
    send_event(ulr_pkg::CMD_TICK, 1'b0, 1'b0);
    send_event(ulr_pkg::CMD_TICK, 1'b1, 1'b1);
    send_frame(8'hFF, 1'b1);
    send_frame(ulr_pkg::CHAR_NL, 1'b0);
  endtask

  // idle timeout of 1 and the longest idle timeout, the longest never firing
  task automatic test_timeout_limits();
    write_timeout(8'd1);
    send_frame(8'h41, 1'b0);
    repeat (3) send_event(ulr_pkg::CMD_TICK, 1'b1, 1'b0);
    write_timeout(8'd255);
    send_frame(8'h00, 1'b0);
    send_frame(8'h42, 1'b0);
    repeat (300) send_event(ulr_pkg::CMD_TICK, 1'b1, 1'($urandom_range(1)));
    send_frame(ulr_pkg::CHAR_NUL, 1'b0);
  endtask

  // fill the line buffer until the last slot aborts it
  task automatic test_line_overflow();
    write_timeout(8'd255);
    repeat (ulr_pkg::LINE_DEPTH + 2) begin
      send_frame(plain_char(), 1'b0);
      repeat ($urandom_range(2)) send_event(ulr_pkg::CMD_TICK, 1'b1, 1'b0);
    end
  endtask

  // long receiver hold-off fills the block, then a full drain
  task automatic test_backpressure();
    write_timeout(8'd255);
    hold_req = 250;
    repeat (10) send_frame(plain_char(), 1'b0);
    wait_drain();
    repeat (3) send_frame(plain_char(), 1'b0);
  endtask

  // mostly well-formed lines with random content, plus noise and cut frames
  task automatic test_random_lines();
    int round;
    int stop_at;
    int pick;
    logic [ulr_pkg::CHAR_W-1:0] ch;
    round = 0;
    while (events_accepted < EVENT_TARGET) begin
      no_idle = (round == 1);
      write_timeout((round == 0) ? 8'd3 : (round == 1) ? 8'd255 :
                    ulr_pkg::IDLE_W'($urandom_range(1, 40)));
      stop_at = events_accepted + ROUND_EVENTS;
      while (events_accepted < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          pick = $urandom_range(99);
          ch = (pick < 10) ? ulr_pkg::CHAR_NL : (pick < 15) ? ulr_pkg::CHAR_NUL :
               ulr_pkg::CHAR_W'($urandom_range(255));
          send_frame(ch, $urandom_range(19) == 0);
          if ($urandom_range(9) == 0)
            repeat ($urandom_range(45))
              send_event(ulr_pkg::CMD_TICK, 1'($urandom_range(1)), 1'b0);
          else
            repeat ($urandom_range(3)) send_event(ulr_pkg::CMD_TICK, 1'b1, 1'b0);
        end else if (pick < 85) begin
          send_event(ulr_pkg::cmd_t'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end else begin
          // frame cut short; later ticks carry on from where it stopped
          send_event(ulr_pkg::CMD_EDGE, 1'b0, 1'b0);
          repeat ($urandom_range(9))
            send_event(ulr_pkg::CMD_TICK, 1'($urandom_range(1)), 1'b0);
        end
      end
      round++;
    end
    no_idle = 1'b0;
  endtask

  // sequence
  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    rx_active      = 1'b0;
    rx_phase       = ulr_pkg::PH_READY;
    rx_shift       = '0;
    rx_pos         = 0;
    rx_idle        = '0;
    rx_idle_limit  = ulr_pkg::IDLE_TIMEOUT_RST;
    mismatch_count = 0;
    events_accepted = 0;
    cycle_count    = 0;
    hold_req       = 0;
    hold_left      = 0;
    no_idle        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_timeout_limits();
    test_line_overflow();
    test_backpressure();
    test_random_lines();

    wait_drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_line_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ulr_pkg.sv
sv/uart_line_receiver_unit.sv
verif/tb.sv
